// ===== hw/rtl/ptwa_pkg.sv =====
// Shared constants, codes and types of the peer table with aging.
package ptwa_pkg;

  localparam int ENTRIES  = 16;
  localparam int IDX_W    = $clog2(ENTRIES);
  localparam int KEY_W    = 64;
  localparam int HALF_W   = 32;
  localparam int CAPS_W   = 8;
  localparam int AGE_W    = 9;
  localparam int SLOT_W   = 4;
  localparam int STATUS_W = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W    = 8;

  localparam logic [STATUS_W-1:0] STS_REFRESHED = 2'd0;
  localparam logic [STATUS_W-1:0] STS_ADDED     = 2'd1;
  localparam logic [STATUS_W-1:0] STS_FULL      = 2'd2;
  localparam logic [STATUS_W-1:0] STS_TICK      = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_AGE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_CAPS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MASTER_MASK = 2'd2;

  localparam logic ACT_ANNOUNCE = 1'b0;
  localparam logic ACT_TICK     = 1'b1;

  typedef struct packed {
    logic              valid;
    logic [KEY_W-1:0]  key;
    logic [CAPS_W-1:0] caps;
    logic [AGE_W-1:0]  age;
  } ent_t;

  typedef struct packed {
    logic              en;
    logic              set_valid;
    logic              clr_valid;
    logic [IDX_W-1:0]  addr;
    logic [KEY_W-1:0]  key;
    logic [CAPS_W-1:0] caps;
    logic [AGE_W-1:0]  age;
  } wr_t;

endpackage

// ===== hw/rtl/ptwa_store.sv =====
// Entry memory with per-entry valid flags and a registered read port.
module ptwa_store (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     rd_en,
  input  logic [ptwa_pkg::IDX_W-1:0] rd_addr,
  output ptwa_pkg::ent_t           rd_ent,
  input  ptwa_pkg::wr_t            wr
);
  import ptwa_pkg::*;

  localparam int WORD_W = KEY_W + CAPS_W + AGE_W;

  logic [WORD_W-1:0]  mem [ENTRIES];
  logic [WORD_W-1:0]  rdata_r;
  logic               rvld_r;
  logic [ENTRIES-1:0] vld_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= {wr.key, wr.caps, wr.age};
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      rvld_r <= 1'b0;
    end else begin
      if (wr.set_valid) begin
        vld_r[wr.addr] <= 1'b1;
      end else if (wr.clr_valid) begin
        vld_r[wr.addr] <= 1'b0;
      end
      if (rd_en) begin
        rvld_r <= vld_r[rd_addr];
      end
    end
  end

  // A free entry always reads as all zero.
  always_comb begin
    rd_ent = '0;
    if (rvld_r) begin
      rd_ent.valid = 1'b1;
      rd_ent.key   = rdata_r[WORD_W-1 -: KEY_W];
      rd_ent.caps  = rdata_r[AGE_W +: CAPS_W];
      rd_ent.age   = rdata_r[AGE_W-1:0];
    end
  end

endmodule

// ===== hw/rtl/peer_table_with_aging.sv =====
// Top level of the peer table with aging: sequencer, scan datapath and ports.
//
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid/in_stall   | action, key_high, key_low, peer_caps
//   out_    | output    | out_valid/out_stall | status, slot, multi_master
//   cfg_    | input     | cfg_we              | cfg_index, cfg_wdata
//
// Every beat scans all ENTRIES entries through one memory read port, one entry
// per cycle, then waits in S_FIN until the output register is free; the next
// beat is taken only once the last one has left S_FIN for S_IDLE.
// Synchronous reset frees all entries at once through the valid flags.
// A new beat is taken while a finished result still waits on out_stall; that
// beat's result is held back until the output register is free.
module peer_table_with_aging (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_action,
  input  logic [ptwa_pkg::HALF_W-1:0]        in_key_high,
  input  logic [ptwa_pkg::HALF_W-1:0]        in_key_low,
  input  logic [ptwa_pkg::CAPS_W-1:0]        in_peer_caps,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [ptwa_pkg::STATUS_W-1:0]      out_status,
  output logic [ptwa_pkg::SLOT_W-1:0]        out_slot,
  output logic                               out_multi_master,
  input  logic                               cfg_we,
  input  logic [ptwa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ptwa_pkg::CFG_W-1:0]         cfg_wdata
);
  import ptwa_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_FIN  = 3'b100
  } state_t;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  state_t st_r, st_nxt;

  logic [CAPS_W-1:0] max_age_r, local_caps_r, master_mask_r;

  logic              action_r;
  logic [KEY_W-1:0]  key_r;
  logic [CAPS_W-1:0] caps_r;

  logic             iss_r, iss_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             p_vld_r;
  logic [IDX_W-1:0] p_idx_r;

  logic             found_r, found_nxt;
  logic [IDX_W-1:0] hit_idx_r, hit_idx_nxt;
  logic             hit_m_r, hit_m_nxt;
  logic             free_r, free_nxt;
  logic [IDX_W-1:0] free_idx_r, free_idx_nxt;
  logic [1:0]       cnt_r, cnt_nxt;

  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [SLOT_W-1:0]   out_slot_r, out_slot_nxt;
  logic                out_mm_r, out_mm_nxt;

  ent_t rd_ent;
  wr_t  wr;

  logic             in_acc;
  logic             fin_go;
  logic             ent_m;
  logic             expire;
  logic             cnt_inc;
  logic             m_new;
  logic             m_loc;
  logic [2:0]       tot;
  logic [IDX_W-1:0] fin_idx;
  logic [IDX_W+SLOT_W-1:0] slot_ext;

  ptwa_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (iss_r),
    .rd_addr (idx_r),
    .rd_ent  (rd_ent),
    .wr      (wr)
  );

  assign in_stall         = (st_r != S_IDLE);
  assign in_acc           = in_valid && !in_stall;
  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_slot         = out_slot_r;
  assign out_multi_master = out_mm_r;

  assign fin_go = (st_r == S_FIN) && (!out_valid_r || !out_stall);
  assign ent_m  = |(rd_ent.caps & master_mask_r);
  assign expire = rd_ent.valid && (rd_ent.age > {1'b0, max_age_r});
  assign m_new  = |(caps_r & master_mask_r);
  assign m_loc  = |(local_caps_r & master_mask_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_age_r     <= CAPS_W'(8);
      local_caps_r  <= '0;
      master_mask_r <= CAPS_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MAX_AGE:     max_age_r     <= cfg_wdata;
        CFG_LOCAL_CAPS:  local_caps_r  <= cfg_wdata;
        CFG_MASTER_MASK: master_mask_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    st_nxt       = st_r;
    iss_nxt      = iss_r;
    idx_nxt      = idx_r;
    found_nxt    = found_r;
    hit_idx_nxt  = hit_idx_r;
    hit_m_nxt    = hit_m_r;
    free_nxt     = free_r;
    free_idx_nxt = free_idx_r;
    cnt_nxt      = cnt_r;
    cnt_inc      = 1'b0;
    wr           = '0;

    if (in_acc) begin
      st_nxt    = S_SCAN;
      iss_nxt   = 1'b1;
      idx_nxt   = '0;
      found_nxt = 1'b0;
      free_nxt  = 1'b0;
      cnt_nxt   = '0;
    end

    if (iss_r) begin
      if (idx_r == LAST_IDX) begin
        iss_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + 1'b1;
      end
    end

    if (p_vld_r) begin
      if (action_r == ACT_TICK) begin
        cnt_inc = ent_m && !expire;
        if (expire) begin
          wr.clr_valid = 1'b1;
          wr.addr      = p_idx_r;
        end else if (rd_ent.valid) begin
          wr.en   = 1'b1;
          wr.addr = p_idx_r;
          wr.key  = rd_ent.key;
          wr.caps = rd_ent.caps;
          wr.age  = rd_ent.age + 1'b1;
        end
      end else begin
        cnt_inc = ent_m;
        if (!found_r) begin
          if (!rd_ent.valid && !free_r) begin
            free_nxt     = 1'b1;
            free_idx_nxt = p_idx_r;
          end
          if (rd_ent.key == key_r) begin
            found_nxt   = 1'b1;
            hit_idx_nxt = p_idx_r;
            hit_m_nxt   = ent_m;
          end
        end
      end
      if (cnt_inc && cnt_r != 2'd3) begin
        cnt_nxt = cnt_r + 1'b1;
      end
      if (p_idx_r == LAST_IDX) begin
        st_nxt = S_FIN;
      end
    end

    if (fin_go) begin
      st_nxt = S_IDLE;
      if (action_r == ACT_ANNOUNCE && (found_r || free_r)) begin
        wr.en        = 1'b1;
        wr.set_valid = 1'b1;
        wr.addr      = fin_idx;
        wr.key       = key_r;
        wr.caps      = caps_r;
        wr.age       = '0;
      end
    end
  end

  assign fin_idx  = found_r ? hit_idx_r : free_idx_r;
  assign slot_ext = {{SLOT_W{1'b0}}, fin_idx};

  always_comb begin
    out_slot_nxt = '0;
    tot          = {1'b0, cnt_r};
    priority if (action_r == ACT_TICK) begin
      out_status_nxt = STS_TICK;
    end else if (found_r) begin
      out_status_nxt = STS_REFRESHED;
      out_slot_nxt   = slot_ext[SLOT_W-1:0];
      tot            = {1'b0, cnt_r} - {2'b0, hit_m_r} + {2'b0, m_new};
    end else if (free_r) begin
      out_status_nxt = STS_ADDED;
      out_slot_nxt   = slot_ext[SLOT_W-1:0];
      tot            = {1'b0, cnt_r} + {2'b0, m_new};
    end else begin
      out_status_nxt = STS_FULL;
    end
    out_mm_nxt = (tot + {2'b0, m_loc}) > 3'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      iss_r       <= 1'b0;
      p_vld_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      iss_r   <= iss_nxt;
      p_vld_r <= iss_r;
      if (fin_go) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    p_idx_r    <= idx_r;
    found_r    <= found_nxt;
    hit_idx_r  <= hit_idx_nxt;
    hit_m_r    <= hit_m_nxt;
    free_r     <= free_nxt;
    free_idx_r <= free_idx_nxt;
    cnt_r      <= cnt_nxt;
    if (in_acc) begin
      action_r <= in_action;
      key_r    <= {in_key_high, in_key_low};
      caps_r   <= in_peer_caps;
    end
    if (fin_go) begin
      out_status_r <= out_status_nxt;
      out_slot_r   <= out_slot_nxt;
      out_mm_r     <= out_mm_nxt;
    end
  end

`ifndef SYNTH
  a_rise_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(st_r == S_FIN))
    else $error("result appeared without a finished scan");

  a_scan_only: assert property (@(posedge clk) disable iff (!rst_n)
    (iss_r || p_vld_r) |-> (st_r == S_SCAN))
    else $error("entry read outside of a scan");

  a_no_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r == STS_TICK || out_status_r == STS_FULL))
      |-> (out_slot_r == '0))
    else $error("nonzero slot on a tick or dropped beat");

  a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
    fin_go |-> !p_vld_r && !iss_r)
    else $error("final write overlaps the scan");
`endif

endmodule
